// File: rtl/core/crc32s8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32s8_pkg
// Shared widths, constants and the lane basis function for the
// reflected CRC-32 (0xEDB88320) slicing engine.
// ----------------------------------------------------------------------------
package crc32s8_pkg;

    localparam int          CRC_W      = 32;
    localparam int          DATA_W     = 64;
    localparam int          COUNT_W    = 4;
    localparam int          BYTE_W     = 8;
    localparam int          DATA_BYTES = DATA_W / BYTE_W;
    localparam int          LANES_DEF  = 8;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] SEED_RESET = 32'h0000_0000;

    // contribution of one set bit of a byte that is followed by lane_dist zero
    // bytes, starting from a zero register; only called with constants
    function automatic logic [CRC_W-1:0] lane_basis(input int lane_dist, input int bit_idx);
        logic [CRC_W-1:0] c;
        int               k;
        c = CRC_W'(1) << bit_idx;
        for (k = 0; k < BYTE_W * (lane_dist + 1); k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/crc32s8_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32s8 channel interfaces
// Valid/ready channels for message words in and CRC results out.
// ----------------------------------------------------------------------------
interface crc32s8_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [crc32s8_pkg::DATA_W-1:0]       data_bytes;
    logic [crc32s8_pkg::COUNT_W-1:0]      byte_count;
    logic                                 first;
    logic                                 last;

    modport source (output valid, output data_bytes, output byte_count,
                    output first, output last, input ready);
    modport sink   (input valid, input data_bytes, input byte_count,
                    input first, input last, output ready);
endinterface

interface crc32s8_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [crc32s8_pkg::CRC_W-1:0]        crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/crc32s8_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32s8_lane
// One slicing lane: CRC contribution of a byte followed by DIST zero bytes.
// ----------------------------------------------------------------------------
module crc32s8_lane #(
    parameter int DIST = 0
) (
    input  wire logic [crc32s8_pkg::BYTE_W-1:0] i_byte,
    output logic      [crc32s8_pkg::CRC_W-1:0]  o_crc
);

    logic [crc32s8_pkg::CRC_W-1:0] term [crc32s8_pkg::BYTE_W];

    // table entry built as xor of per-bit basis vectors (the map is linear)
    for (genvar gj = 0; gj < crc32s8_pkg::BYTE_W; gj++) begin : g_bit
        localparam logic [crc32s8_pkg::CRC_W-1:0] BASIS =
            crc32s8_pkg::lane_basis(DIST, gj);
        assign term[gj] = i_byte[gj] ? BASIS : '0;
    end

    always_comb begin
        o_crc = '0;
        for (int j = 0; j < crc32s8_pkg::BYTE_W; j++) begin
            o_crc = o_crc ^ term[j];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/crc32s8_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32s8_fold
// Folds up to LANES bytes of one word into a running CRC: byte alignment,
// parallel lane lookups and the xor merge.
// ----------------------------------------------------------------------------
module crc32s8_fold #(
    parameter int LANES = crc32s8_pkg::LANES_DEF
) (
    input  wire logic [crc32s8_pkg::CRC_W-1:0]   i_crc,
    input  wire logic [crc32s8_pkg::DATA_W-1:0]  i_data,
    input  wire logic [crc32s8_pkg::COUNT_W-1:0] i_count,
    output logic      [crc32s8_pkg::CRC_W-1:0]   o_crc
);

    localparam int NW = $clog2(LANES + 1);

    logic [NW-1:0]                  num;
    logic [4:0]                     num_x;
    logic [crc32s8_pkg::BYTE_W-1:0] msg_byte  [LANES];
    logic [crc32s8_pkg::BYTE_W-1:0] lane_byte [LANES];
    logic [crc32s8_pkg::CRC_W-1:0]  lane_crc  [LANES];
    logic [crc32s8_pkg::CRC_W-1:0]  residual;

    // counts above the lane count saturate
    assign num   = (5'(i_count) > 5'(LANES)) ? NW'(LANES) : NW'(i_count);
    assign num_x = 5'(num);

    // message byte j: data byte (zero past the word) xor the running crc byte
    for (genvar gj = 0; gj < LANES; gj++) begin : g_msg
        logic [crc32s8_pkg::BYTE_W-1:0] data_part;
        logic [crc32s8_pkg::BYTE_W-1:0] crc_part;
        if (gj < crc32s8_pkg::DATA_BYTES) begin : g_in
            assign data_part = i_data[crc32s8_pkg::BYTE_W*gj +: crc32s8_pkg::BYTE_W];
        end else begin : g_out
            assign data_part = '0;
        end
        if (gj < crc32s8_pkg::CRC_W / crc32s8_pkg::BYTE_W) begin : g_crc
            assign crc_part = i_crc[crc32s8_pkg::BYTE_W*gj +: crc32s8_pkg::BYTE_W];
        end else begin : g_nocrc
            assign crc_part = '0;
        end
        assign msg_byte[gj] = data_part ^ crc_part;
    end

    // right-align the valid bytes so the last one lands in the top lane
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            lane_byte[i] = '0;
            for (int j = 0; j <= i; j++) begin
                if (num_x == 5'(LANES - i + j)) begin
                    lane_byte[i] = msg_byte[j];
                end
            end
        end
    end

    for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
        crc32s8_lane #(
            .DIST (LANES - 1 - gi)
        ) u_lane (
            .i_byte (lane_byte[gi]),
            .o_crc  (lane_crc[gi])
        );
    end

    // crc bytes not consumed by a short word shift through
    always_comb begin
        case (num_x)
            5'd0:    residual = i_crc;
            5'd1:    residual = {8'b0,  i_crc[31:8]};
            5'd2:    residual = {16'b0, i_crc[31:16]};
            5'd3:    residual = {24'b0, i_crc[31:24]};
            default: residual = '0;
        endcase
    end

    always_comb begin
        o_crc = residual;
        for (int i = 0; i < LANES; i++) begin
            o_crc = o_crc ^ lane_crc[i];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/crc32_ieee_slicing_by_eight.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_ieee_slicing_by_eight
// Streaming reflected CRC-32, one word of up to LANES bytes per cycle while the skid entry is empty.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the skid entry is empty; the running CRC loop
//   through the lanes and the xor merge is combinational.
// Result: registered into the output register, or the skid entry if it is held.
// A two-entry output buffer keeps input flowing while a result waits.
// Reset: running CRC to all ones, seed to zero, output buffer emptied.
// ----------------------------------------------------------------------------
module crc32_ieee_slicing_by_eight #(
    parameter int LANES = crc32s8_pkg::LANES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [crc32s8_pkg::CRC_W-1:0]   i_cfg_wdata,
    crc32s8_in_if.sink                           i_in,
    crc32s8_out_if.source                        o_out
);

    logic [crc32s8_pkg::CRC_W-1:0] r_seed;
    logic [crc32s8_pkg::CRC_W-1:0] r_crc;
    logic [crc32s8_pkg::CRC_W-1:0] n_crc;
    logic [crc32s8_pkg::CRC_W-1:0] crc_start;
    logic                          r_out_valid;
    logic [crc32s8_pkg::CRC_W-1:0] r_out_crc;
    logic                          r_skid_valid;
    logic [crc32s8_pkg::CRC_W-1:0] r_skid_crc;
    logic                          in_xfer;
    logic                          push;
    logic                          pop;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign push      = in_xfer && i_in.last;
    assign pop       = r_out_valid && o_out.ready;
    assign crc_start = i_in.first ? ~r_seed : r_crc;

    crc32s8_fold #(
        .LANES (LANES)
    ) u_fold (
        .i_crc   (crc_start),
        .i_data  (i_in.data_bytes),
        .i_count (i_in.byte_count),
        .o_crc   (n_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= crc32s8_pkg::SEED_RESET;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= crc32s8_pkg::CRC_INIT;
        end else if (in_xfer) begin
            r_crc <= n_crc;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_crc <= r_skid_crc;
            end else begin
                r_out_crc <= ~n_crc;
            end
        end else if (push) begin
            r_skid_crc <= ~n_crc;
        end
    end

    assign i_in.ready      = !r_skid_valid;
    assign o_out.valid     = r_out_valid;
    assign o_out.crc_value = r_out_crc;

endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming CRC-32 engine. Message words go in
// through the valid/ready input channel with random gaps, and CRC results
// are taken with random back-pressure. A scoreboard keeps its own bitwise
// CRC state and seed and compares every result in order. The run starts with
// directed corner words, then random messages under several seed settings.
// ----------------------------------------------------------------------------
module tb;
    import crc32s8_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 320;
    localparam int MAX_WAIT      = 12;

    // ------------------------------------------------------------------------
    class CrcScoreboard;
        logic [CRC_W-1:0] seed_reg;
        logic [CRC_W-1:0] running_crc;
        logic [CRC_W-1:0] expected_crcs[$];
        int unsigned      error_count;

        function new();
            seed_reg    = SEED_RESET;
            running_crc = CRC_INIT;
            error_count = 0;
        endfunction

        function void set_seed(input logic [CRC_W-1:0] value);
            seed_reg = value;
        endfunction

        // fold the valid bytes of an accepted word, lane 0 first
        function void note_word(input logic [DATA_W-1:0] data,
                                input logic [COUNT_W-1:0] count,
                                input logic first, input logic last);
            logic [CRC_W-1:0] c;
            int               nbytes;
            int               i;
            int               k;
            nbytes = (count > DATA_BYTES) ? DATA_BYTES : int'(count);
            c = first ? ~seed_reg : running_crc;
            for (i = 0; i < nbytes; i++) begin
                c = c ^ {{(CRC_W-BYTE_W){1'b0}}, data[BYTE_W*i +: BYTE_W]};
                for (k = 0; k < BYTE_W; k++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
            end
            running_crc = c;
            if (last) begin
                expected_crcs.push_back(~c);
            end
        endfunction

        function void check_crc(input logic [CRC_W-1:0] actual);
            logic [CRC_W-1:0] want_crc;
            if (expected_crcs.size() == 0) begin
                $error("crc_value: no result expected, actual %08h", actual);
                error_count++;
                return;
            end
            want_crc = expected_crcs.pop_front();
            if (actual !== want_crc) begin
                $error("crc_value: expected %08h, actual %08h", want_crc, actual);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_crcs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CRC_W-1:0]   cfg_wdata;

    crc32s8_in_if  in_if ();
    crc32s8_out_if out_if ();

    crc32_ieee_slicing_by_eight DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    CrcScoreboard crc_board;

    int unsigned cycle_count;
    int unsigned sent_words;
    int unsigned taken_results;
    bit          send_gaps_on;
    bit          take_stalls_on;
    int          sink_hold_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: sample each transfer at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            crc_board.check_crc(out_if.crc_value);
        end
    end

    // gaps come in stretches: some runs of 64 transfers have none at all
    function int draw_send_gap();
        if (sent_words % 64 == 0) begin
            send_gaps_on = ($urandom_range(0, 2) != 0);
        end
        sent_words++;
        return send_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function int draw_take_stall();
        if (taken_results % 64 == 0) begin
            take_stalls_on = ($urandom_range(0, 2) != 0);
        end
        taken_results++;
        return take_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function logic [COUNT_W-1:0] draw_byte_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return COUNT_W'(DATA_BYTES);
        if (r < 85) return COUNT_W'($urandom_range(1, DATA_BYTES - 1));
        if (r < 90) return '0;
        return COUNT_W'($urandom_range(DATA_BYTES + 1, (1 << COUNT_W) - 1));
    endfunction

    function logic [DATA_W-1:0] draw_data();
        return {$urandom, $urandom};
    endfunction

    // ready driver, with an occasional long hold-off on request
    initial begin
        int stall;
        int hold;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (sink_hold_cycles > 0) begin
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
                repeat (hold) begin
                    @(negedge clk);
                    out_if.ready <= 1'b0;
                end
            end
            stall = draw_take_stall();
            repeat (stall) begin
                @(negedge clk);
                out_if.ready <= 1'b0;
            end
            @(negedge clk);
            out_if.ready <= 1'b1;
            do @(posedge clk); while (!(out_if.valid && out_if.ready));
        end
    end

    task automatic send_word(input logic [DATA_W-1:0] data,
                             input logic [COUNT_W-1:0] count,
                             input logic first, input logic last);
        int gap;
        gap = draw_send_gap();
        repeat (gap) begin
            @(negedge clk);
            in_if.valid <= 1'b0;
        end
        @(negedge clk);
        in_if.valid      <= 1'b1;
        in_if.data_bytes <= data;
        in_if.byte_count <= count;
        in_if.first      <= first;
        in_if.last       <= last;
        do @(posedge clk); while (!in_if.ready);
        crc_board.note_word(data, count, first, last);
    endtask

    // sender stops offering and waits until every result is back
    task automatic wait_results_drained();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (crc_board.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [CRC_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        crc_board.set_seed(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CRC_W-1:0] seed_value, input int items,
                             input bit with_hold);
        int left;
        int words;
        int w;
        bit noisy;
        bit hold_pending;
        wait_results_drained();
        write_seed(seed_value);
        left = items;
        hold_pending = with_hold;
        while (left > 0) begin
            if (hold_pending && left < items / 2) begin
                // long receiver hold-off while one-word messages keep coming
                hold_pending = 1'b0;
                sink_hold_cycles = 400;
                repeat (30) send_word(draw_data(), draw_byte_count(), 1'b1, 1'b1);
                left -= 30;
            end
            words = $urandom_range(1, 6);
            noisy = ($urandom_range(0, 9) == 0);
            for (w = 0; w < words; w++) begin
                if (noisy) begin
                    send_word(draw_data(), COUNT_W'($urandom_range(0, (1 << COUNT_W) - 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    send_word(draw_data(), draw_byte_count(), w == 0, w == words - 1);
                end
            end
            left -= words;
        end
    endtask

    initial begin
        crc_board        = new();
        cycle_count      = 0;
        sent_words       = 0;
        taken_results    = 0;
        send_gaps_on     = 1'b1;
        take_stalls_on   = 1'b1;
        sink_hold_cycles = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_if.valid      = 1'b0;
        in_if.data_bytes = '0;
        in_if.byte_count = '0;
        in_if.first      = 1'b0;
        in_if.last       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_seed(32'h0000_0000);
        // no first after reset: continues from the all-ones state
        send_word(64'h0000_0000_3433_3231, 4'd4, 1'b0, 1'b1);
        // "123456789" split over two words
        send_word(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0);
        send_word(64'h0000_0000_0000_0039, 4'd1, 1'b0, 1'b1);
        // continue after last without a new first
        send_word(64'h0000_0000_0000_0000, 4'd3, 1'b0, 1'b1);
        send_word({DATA_W{1'b1}}, 4'd8, 1'b1, 1'b1);
        send_word({DATA_W{1'b0}}, 4'd8, 1'b1, 1'b1);
        // zero count with both flags returns the seed
        send_word(draw_data(), 4'd0, 1'b1, 1'b1);
        // counts above eight saturate
        send_word({DATA_W{1'b1}}, 4'd15, 1'b1, 1'b1);
        send_word({(DATA_W/8){8'hA5}}, 4'd9, 1'b1, 1'b0);
        send_word({(DATA_W/8){8'h5A}}, 4'd0, 1'b0, 1'b0);
        send_word(64'h0123_4567_89AB_CDEF, 4'd5, 1'b0, 1'b1);
        // words without last give nothing until the closing one
        send_word(draw_data(), 4'd8, 1'b1, 1'b0);
        send_word(draw_data(), 4'd7, 1'b0, 1'b0);
        send_word(draw_data(), 4'd2, 1'b0, 1'b1);
        wait_results_drained();
        write_seed(32'hDEAD_BEEF);
        send_word(draw_data(), 4'd0, 1'b1, 1'b1);
        send_word(64'h8000_0000_0000_0001, 4'd1, 1'b1, 1'b1);
        send_word(draw_data(), 4'd8, 1'b1, 1'b1);
        send_word(draw_data(), 4'd12, 1'b0, 1'b1);

        run_phase(32'hFFFF_FFFF, PHASE_ITEMS, 1'b0);
        run_phase(32'h0000_0000, PHASE_ITEMS, 1'b1);
        run_phase($urandom, PHASE_ITEMS, 1'b0);
        run_phase(32'h0000_0001, PHASE_ITEMS, 1'b0);
        run_phase(32'h8000_0000, PHASE_ITEMS, 1'b1);
        run_phase($urandom, PHASE_ITEMS, 1'b0);

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (crc_board.error_count == 0 && crc_board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
